@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the frame parser RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held
`define FLP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// Next-cycle implication, off while reset is held
`define FLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

@@ hw/rtl/flp_pkg.sv @@
// Types and constants of the length-prefixed frame parser.
// No dependencies; imported by every parser module but flp_in_reg.
package flp_pkg;

  localparam int unsigned MAX_LEN_W = 21;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned HDR_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_HDR = 2'd1;

  localparam logic [31:0]          RELAY_MAGIC   = 32'h4C52_4E45;
  localparam logic [7:0]           RELAY_VERSION = 8'd1;
  localparam logic [31:0]          HARD_LIMIT    = 32'h0010_0000;
  localparam logic [HDR_IDX_W-1:0] HEADER_BYTES  = 4'd14;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 21'h10_0000;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_HDR_ONLY = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_HDR  = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_byte;
    logic [7:0]  msg_type;
    logic [31:0] session;
    logic [31:0] client;
    logic        last;
  } result_t;

endpackage

@@ hw/rtl/flp_in_reg.sv @@
// Input register of the frame parser: holds one stream byte for the core.
// Depends on nothing beyond its ports.
module flp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  output logic       in_stall,
  input  logic       advance,
  output logic       vld,
  output logic [7:0] byte_q
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  // stall only while a held beat cannot move on
  assign in_stall = vld_r && !advance;
  assign vld_nxt  = in_stall ? vld_r : in_valid;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // capture the beat whenever the register is free
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_data_byte;
    end
  end

  assign vld    = vld_r;
  assign byte_q = byte_r;

endmodule

@@ hw/rtl/flp_core.sv @@
// Frame parser core: prefix, header and body tracking for one byte a cycle while fire is high.
// Depends on flp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module flp_core import flp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           data_byte,
  input  logic [MAX_LEN_W-1:0] max_len,
  input  logic                 expect_header,
  output logic                 res_vld,
  output result_t              res
);

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             pidx_r, pidx_nxt;
  logic [23:0]            len_r, len_nxt;
  logic [MAX_LEN_W-1:0]   rem_r, rem_nxt;
  logic [HDR_IDX_W-1:0]   hidx_r, hidx_nxt;
  logic [31:0]            magic_r, magic_nxt;
  logic [7:0]             ver_r, ver_nxt;
  logic [7:0]             type_r, type_nxt;
  logic [31:0]            sess_r, sess_nxt;
  logic [31:0]            cli_r, cli_nxt;
  logic                   good_r, good_nxt;

  logic [MAX_LEN_W-1:0]   rem_dec;
  logic                   rem_end;
  logic [31:0]            len_full;
  logic                   len_bad;
  logic                   hdr_last;
  logic                   hdr_match;
  logic [1:0]             lane;

  // shared step terms
  assign rem_dec   = (rem_r != '0) ? rem_r - MAX_LEN_W'(1) : '0;
  assign rem_end   = (rem_dec == '0);
  assign len_full  = {data_byte, len_r};
  assign len_bad   = (len_full == 32'd0) || (len_full > {11'd0, max_len}) ||
                     (len_full > HARD_LIMIT);
  assign hdr_last  = (hidx_r == HEADER_BYTES - HDR_IDX_W'(1));
  assign hdr_match = (magic_r == RELAY_MAGIC) && (ver_r == RELAY_VERSION);
  // session and client lanes both start at an index that is 2 mod 4
  assign lane      = (hidx_r < HDR_IDX_W'(4)) ? hidx_r[1:0] : hidx_r[1:0] - 2'd2;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pidx_nxt  = pidx_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    hidx_nxt  = hidx_r;
    magic_nxt = magic_r;
    ver_nxt   = ver_r;
    type_nxt  = type_r;
    sess_nxt  = sess_r;
    cli_nxt   = cli_r;
    good_nxt  = good_r;
    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          // capture the header byte into its field
          if (hidx_r < HDR_IDX_W'(4)) begin
            magic_nxt[8*lane +: 8] = data_byte;
          end else if (hidx_r == HDR_IDX_W'(4)) begin
            ver_nxt = data_byte;
          end else if (hidx_r == HDR_IDX_W'(5)) begin
            type_nxt = data_byte;
          end else if (hidx_r < HDR_IDX_W'(10)) begin
            sess_nxt[8*lane +: 8] = data_byte;
          end else begin
            cli_nxt[8*lane +: 8] = data_byte;
          end
          hidx_nxt = hidx_r + HDR_IDX_W'(1);
          rem_nxt  = rem_dec;
          if (hdr_last) begin
            good_nxt = hdr_match;
            if (hdr_match) begin
              phase_nxt = rem_end ? PH_PREFIX : PH_BODY;
            end else begin
              phase_nxt = rem_end ? PH_PREFIX : PH_BODY;
            end
          end else if (rem_end) begin
            phase_nxt = PH_PREFIX;
          end
        end
        PH_BODY: begin
          rem_nxt = rem_dec;
          if (rem_end) begin
            phase_nxt = PH_PREFIX;
          end
        end
        default: begin
          // length prefix, also any unused phase code
          phase_nxt = PH_PREFIX;
          if (pidx_r != 2'd3) begin
            len_nxt[8*pidx_r +: 8] = data_byte;
            pidx_nxt = pidx_r + 2'd1;
          end else begin
            pidx_nxt = 2'd0;
            if (!len_bad) begin
              rem_nxt   = len_full[MAX_LEN_W-1:0];
              hidx_nxt  = '0;
              magic_nxt = '0;
              ver_nxt   = '0;
              type_nxt  = '0;
              sess_nxt  = '0;
              cli_nxt   = '0;
              good_nxt  = !expect_header;
              phase_nxt = expect_header ? PH_HEADER : PH_BODY;
            end
          end
        end
      endcase
    end
  end

  // result of the current beat
  always_comb begin
    res_vld      = 1'b0;
    res.status   = ST_PAYLOAD;
    res.out_byte = '0;
    res.msg_type = type_nxt;
    res.session  = sess_nxt;
    res.client   = cli_nxt;
    res.last     = 1'b0;
    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (hdr_last && !hdr_match) begin
            res_vld    = 1'b1;
            res.status = ST_BAD_HDR;
          end else if (hdr_last && rem_end) begin
            res_vld    = 1'b1;
            res.status = ST_HDR_ONLY;
          end else if (!hdr_last && rem_end) begin
            res_vld    = 1'b1;
            res.status = ST_BAD_HDR;
          end
        end
        PH_BODY: begin
          res_vld      = good_r;
          res.out_byte = data_byte;
          res.last     = rem_end;
        end
        default: begin
          if (pidx_r == 2'd3 && len_bad) begin
            res_vld      = 1'b1;
            res.status   = ST_BAD_LEN;
            res.msg_type = '0;
            res.session  = '0;
            res.client   = '0;
          end
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      pidx_r  <= '0;
      rem_r   <= '0;
      hidx_r  <= '0;
      good_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pidx_r  <= pidx_nxt;
      rem_r   <= rem_nxt;
      hidx_r  <= hidx_nxt;
      good_r  <= good_nxt;
    end
  end

  // captured prefix and header bytes
  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    magic_r <= magic_nxt;
    ver_r   <= ver_nxt;
    type_r  <= type_nxt;
    sess_r  <= sess_nxt;
    cli_r   <= cli_nxt;
  end

  `FLP_ASSERT_IMPL(a_res_needs_fire, res_vld, fire)
  `FLP_ASSERT_IMPL(a_frame_has_bytes, phase_r != PH_PREFIX, rem_r != '0)
  `FLP_ASSERT_IMPL(a_hdr_idx_range, phase_r == PH_HEADER, hidx_r < HEADER_BYTES)
  `FLP_ASSERT_NEXT(a_prefix_after_bad_len,
                   res_vld && res.status == ST_BAD_LEN,
                   phase_r == PH_PREFIX && pidx_r == 2'd0)

endmodule

@@ hw/rtl/flp_out_reg.sv @@
// Result register of the frame parser: holds one result beat for the receiver.
// Depends on flp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module flp_out_reg import flp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_vld,
  input  result_t     res,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_msg_type,
  output logic [31:0] out_session,
  output logic [31:0] out_client,
  output logic        out_last
);

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  // the register is free when empty or when its beat leaves this cycle
  assign advance = !vld_r || !out_stall;
  assign vld_nxt = advance ? res_vld : vld_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // load a new result beat
  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid    = vld_r;
  assign out_status   = res_r.status;
  assign out_byte     = res_r.out_byte;
  assign out_msg_type = res_r.msg_type;
  assign out_session  = res_r.session;
  assign out_client   = res_r.client;
  assign out_last     = res_r.last;

  `FLP_ASSERT_IMPL(a_load_only_when_free, res_vld, advance)

endmodule

@@ hw/rtl/length_prefixed_frame_parser.sv @@
// Length-prefixed frame parser, top level.
// Depends on flp_pkg, flp_in_reg, flp_core and flp_out_reg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte) takes one stream byte
//   per beat. Every frame opens with a 4-byte little-endian length. In header
//   mode the first 14 frame bytes are a relay header (magic, version, type,
//   session id, client id); later bytes come out as payload with out_last on
//   the final one. In raw mode every frame byte comes out as payload.
//   Result channel (out_valid / out_stall / out_*) gives zero or one beat per
//   input byte: payload, header-only frame, bad length or bad header.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   index 0 is max_len, index 1 is expect_header; cfg_ready is always high.
//   Write it only while no byte is in flight.
// Timing:
//   One byte a cycle sustained while out_stall stays low. A result passes
//   through the input register, then the result register, to the outputs.
//   While out_stall holds a waiting result, a byte in the input register
//   cannot advance and in_stall rises in that same cycle.
// Reset (rst_n low, synchronous): both registers empty, parser waits for a
//   length prefix, max_len = 1048576, expect_header = 1.
module length_prefixed_frame_parser import flp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [7:0]           out_byte,
  output logic [7:0]           out_msg_type,
  output logic [31:0]          out_session,
  output logic [31:0]          out_client,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic                 max_len_we;
  logic [MAX_LEN_W-1:0] max_len_r;
  logic                 exp_hdr_r;
  logic                 advance;
  logic                 fire;
  logic                 byte_vld;
  logic [7:0]           byte_q;
  logic                 res_vld;
  result_t              res;

  assign cfg_ready  = 1'b1;
  assign max_len_we = cfg_valid && cfg_ready && (cfg_index == CFG_MAX_LEN);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      exp_hdr_r <= 1'b1;
    end else begin
      if (max_len_we) begin
        max_len_r <= cfg_data[MAX_LEN_W-1:0];
      end
      if (cfg_valid && cfg_ready && (cfg_index == CFG_EXPECT_HDR)) begin
        exp_hdr_r <= cfg_data[0];
      end
    end
  end

  flp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .advance      (advance),
    .vld          (byte_vld),
    .byte_q       (byte_q)
  );

  // process the held byte when the result register can take its result
  assign fire = byte_vld && advance;

  flp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .data_byte     (byte_q),
    .max_len       (max_len_r),
    .expect_header (exp_hdr_r),
    .res_vld       (res_vld),
    .res           (res)
  );

  flp_out_reg u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_vld      (res_vld),
    .res          (res),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_byte     (out_byte),
    .out_msg_type (out_msg_type),
    .out_session  (out_session),
    .out_client   (out_client),
    .out_last     (out_last)
  );

endmodule

@@ sim/flp_result_checker.sv @@
// Result checker for the length-prefixed frame parser.
// Tracks the parser state from accepted input beats and compares every result beat.
// Depends on flp_pkg for the result layout, status codes and header constants.
`timescale 1ns / 100ps

module flp_result_checker import flp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_status,
  input  logic [7:0]           out_byte,
  input  logic [7:0]           out_msg_type,
  input  logic [31:0]          out_session,
  input  logic [31:0]          out_client,
  input  logic                 out_last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   pending_count,
  output int                   checked_count
);

  // Shadow copy of the registers
  logic [MAX_LEN_W-1:0] max_len;
  logic                 expect_hdr;

  // Shadow copy of the parser state
  phase_t               parse_phase;
  logic [1:0]           prefix_idx;
  logic [31:0]          length_acc;
  logic [MAX_LEN_W-1:0] bytes_left;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [31:0]          hdr_magic;
  logic [7:0]           hdr_version;
  logic [7:0]           hdr_type;
  logic [31:0]          hdr_session;
  logic [31:0]          hdr_client;
  logic                 hdr_good;

  result_t predicted_results[$];

  // Build a result beat; header fields only where the status carries them
  function automatic result_t frame_result(status_t st, logic [7:0] data, bit with_hdr,
                                           bit is_last);
    result_t r;
    r.status   = st;
    r.out_byte = data;
    r.msg_type = with_hdr ? hdr_type : 8'd0;
    r.session  = with_hdr ? hdr_session : 32'd0;
    r.client   = with_hdr ? hdr_client : 32'd0;
    r.last     = is_last;
    return r;
  endfunction

  // Append one expected result beat at the tail
  task automatic queue_result(input result_t r);
    predicted_results.insert(predicted_results.size(), r);
  endtask

  // Advance the shadow parser by one stream byte and queue any result it causes
  task automatic parse_byte(input logic [7:0] b);
    logic [31:0] word;
    word = {24'd0, b};
    case (parse_phase)
      PH_HEADER: begin
        // capture header fields, little-endian
        if (hdr_idx < 4)
          hdr_magic = hdr_magic | (word << (8 * int'(hdr_idx)));
        else if (hdr_idx == 4)
          hdr_version = b;
        else if (hdr_idx == 5)
          hdr_type = b;
        else if (hdr_idx < 10)
          hdr_session = hdr_session | (word << (8 * (int'(hdr_idx) - 6)));
        else if (hdr_idx < HEADER_BYTES)
          hdr_client = hdr_client | (word << (8 * (int'(hdr_idx) - 10)));
        hdr_idx = hdr_idx + 1'b1;
        if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
        if (hdr_idx == HEADER_BYTES) begin
          hdr_good = (hdr_magic == RELAY_MAGIC) && (hdr_version == RELAY_VERSION);
          if (!hdr_good) begin
            // drop the rest of the frame silently
            parse_phase = (bytes_left != 0) ? PH_BODY : PH_PREFIX;
            queue_result(frame_result(ST_BAD_HDR, 8'd0, 1'b1, 1'b0));
          end else if (bytes_left == 0) begin
            parse_phase = PH_PREFIX;
            queue_result(frame_result(ST_HDR_ONLY, 8'd0, 1'b1, 1'b0));
          end else begin
            parse_phase = PH_BODY;
          end
        end else if (bytes_left == 0) begin
          // frame ended inside the header
          parse_phase = PH_PREFIX;
          queue_result(frame_result(ST_BAD_HDR, 8'd0, 1'b1, 1'b0));
        end
      end
      PH_BODY: begin
        if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) parse_phase = PH_PREFIX;
        if (hdr_good)
          queue_result(frame_result(ST_PAYLOAD, b, 1'b1, bytes_left == 0));
      end
      default: begin
        // collect the length prefix; an unused phase code lands here too
        parse_phase = PH_PREFIX;
        length_acc  = length_acc | (word << (8 * int'(prefix_idx)));
        if (prefix_idx != 2'd3) begin
          prefix_idx = prefix_idx + 1'b1;
        end else begin
          prefix_idx = 2'd0;
          if (length_acc == 0 || length_acc > {11'd0, max_len} || length_acc > HARD_LIMIT) begin
            queue_result(frame_result(ST_BAD_LEN, 8'd0, 1'b0, 1'b0));
          end else begin
            bytes_left  = length_acc[MAX_LEN_W-1:0];
            hdr_idx     = '0;
            hdr_magic   = 32'd0;
            hdr_version = 8'd0;
            hdr_type    = 8'd0;
            hdr_session = 32'd0;
            hdr_client  = 32'd0;
            hdr_good    = 1'b0;
            if (expect_hdr) begin
              parse_phase = PH_HEADER;
            end else begin
              parse_phase = PH_BODY;
              hdr_good    = 1'b1;
            end
          end
          length_acc = 32'd0;
        end
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Watch all three channels on each edge
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      max_len     = MAX_LEN_RESET;
      expect_hdr  = 1'b1;
      parse_phase = PH_PREFIX;
      prefix_idx  = 2'd0;
      length_acc  = 32'd0;
      bytes_left  = '0;
      hdr_idx     = '0;
      hdr_magic   = 32'd0;
      hdr_version = 8'd0;
      hdr_type    = 8'd0;
      hdr_session = 32'd0;
      hdr_client  = 32'd0;
      hdr_good    = 1'b0;
      predicted_results.delete();
    end else begin
      // register write beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_LEN:    max_len = cfg_data[MAX_LEN_W-1:0];
          CFG_EXPECT_HDR: expect_hdr = cfg_data[0];
          default: ;
        endcase
      end
      // stream byte beat
      if (in_valid && !in_stall) parse_byte(in_data_byte);
      // result beat
      if (out_valid && !out_stall) begin
        checked_count++;
        if (predicted_results.size() == 0) begin
          $display("%0t: result beat with none predicted: status %0d byte %0h",
                   $time, out_status, out_byte);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("out_byte", want.out_byte, out_byte);
          check_field("msg_type", want.msg_type, out_msg_type);
          check_field("session", want.session, out_session);
          check_field("client", want.client, out_client);
          check_field("last", want.last, out_last);
        end
      end
    end
    pending_count <= predicted_results.size();
  end

endmodule

@@ sim/length_prefixed_frame_parser_tb.sv @@
// Testbench top for the length-prefixed frame parser.
// Drives framed byte streams and register settings; flp_result_checker does the checking.
// Depends on flp_pkg, length_prefixed_frame_parser and flp_result_checker.
`timescale 1ns / 100ps

module length_prefixed_frame_parser_tb;
  import flp_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD    = 300;
  localparam int SEG_COUNT    = 8;
  localparam int SEG_BYTES    = 85;
  localparam int HOLD_SEG     = 4;
  localparam int TIMEOUT_NS   = 2_000_000;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic [7:0]           in_data_byte = 8'd0;
  logic                 out_stall    = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_MAX_LEN;
  logic [31:0]          cfg_data     = 32'd0;

  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_byte;
  logic [7:0]  out_msg_type;
  logic [31:0] out_session;
  logic [31:0] out_client;
  logic        out_last;
  logic        cfg_ready;

  int fail_count;
  int pending_count;
  int checked_count;

  // Stimulus bookkeeping
  int          send_idle_pct    = 0;
  int          stall_pct        = 0;
  int          bytes_sent       = 0;
  int          settings_applied = 0;
  logic [31:0] cur_max_len      = 32'd1048576;
  bit          cur_hdr          = 1'b1;

  // Long output hold request, toggled by the stimulus
  bit hold_toggle = 1'b0;
  bit hold_seen   = 1'b0;
  int hold_left   = 0;

  // Per-segment register settings and idle mixes
  int unsigned seg_max_len [SEG_COUNT] = '{1048576, 1048576, 40, 1048575,
                                           1048576, 14, 1, 1048576};
  bit          seg_hdr     [SEG_COUNT] = '{1, 0, 1, 0, 0, 1, 0, 1};
  int          idle_tbl    [4]         = '{0, 48, 0, 26};
  int          stall_tbl   [4]         = '{0, 0, 48, 26};

  always #CLK_HALF clk = ~clk;

  length_prefixed_frame_parser DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_byte     (out_byte),
    .out_msg_type (out_msg_type),
    .out_session  (out_session),
    .out_client   (out_client),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  flp_result_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_byte      (out_byte),
    .out_msg_type  (out_msg_type),
    .out_session   (out_session),
    .out_client    (out_client),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // Receiver: random stalls, or a long hold when requested
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one byte, idling at random first, and hold it until the beat is taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_length(input logic [31:0] v);
    for (int i = 0; i < 4; i++) send_byte(v[8*i +: 8]);
  endtask

  // Prefix plus frame bytes; in header mode the first bytes carry the relay header
  task automatic send_relay_frame(input int unsigned len, input logic [31:0] magic,
                                  input logic [7:0] version, input logic [7:0] mtype,
                                  input logic [31:0] session, input logic [31:0] client);
    logic [7:0] hdr_bytes [14];
    for (int k = 0; k < 4; k++) begin
      hdr_bytes[k]      = magic[8*k +: 8];
      hdr_bytes[6 + k]  = session[8*k +: 8];
      hdr_bytes[10 + k] = client[8*k +: 8];
    end
    hdr_bytes[4] = version;
    hdr_bytes[5] = mtype;
    send_length(len);
    for (int unsigned i = 0; i < len; i++)
      send_byte((cur_hdr && i < 14) ? hdr_bytes[i] : 8'($urandom_range(255)));
  endtask

  // Write both registers back to back
  task automatic apply_settings(input logic [31:0] max_len, input bit hdr_mode);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_LEN;
    cfg_data  <= max_len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_EXPECT_HDR;
    cfg_data  <= {31'd0, hdr_mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    cur_max_len = max_len;
    cur_hdr     = hdr_mode;
    settings_applied++;
  endtask

  // Stop sending, wait for every predicted result, then let the pipeline empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          seg_end;
    int          pick;
    int unsigned len;
    logic [31:0] magic;
    logic [7:0]  version;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bad lengths, header-only, payload, short and mismatched headers
    send_length(32'd0);
    send_length(HARD_LIMIT + 32'd1);
    send_length(32'hFFFF_FFFF);
    send_relay_frame(14, RELAY_MAGIC, RELAY_VERSION, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_relay_frame(15, RELAY_MAGIC, RELAY_VERSION, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_relay_frame(18, RELAY_MAGIC, RELAY_VERSION, 8'h5A, 32'h1234_5678, 32'h9ABC_DEF0);
    send_relay_frame(1, RELAY_MAGIC, RELAY_VERSION, 8'h11, 32'h1, 32'h2);
    send_relay_frame(13, RELAY_MAGIC, RELAY_VERSION, 8'h22, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_relay_frame(16, RELAY_MAGIC ^ 32'h8000_0000, RELAY_VERSION, 8'h33, 32'h3, 32'h4);
    send_relay_frame(14, RELAY_MAGIC, 8'h00, 8'h44, 32'h5, 32'h6);
    send_relay_frame(20, RELAY_MAGIC, 8'hFF, 8'h55, 32'h7, 32'h8);

    // Directed: length exactly at and just above max_len
    wait_drained();
    apply_settings(20, 1'b1);
    send_relay_frame(20, RELAY_MAGIC, RELAY_VERSION, 8'h66, 32'h9, 32'hA);
    send_length(32'd21);

    // Directed: smallest max_len in raw and header mode
    wait_drained();
    apply_settings(1, 1'b0);
    send_relay_frame(1, RELAY_MAGIC, RELAY_VERSION, 8'h00, 32'h0, 32'h0);
    send_length(32'd2);
    wait_drained();
    apply_settings(1, 1'b1);
    send_relay_frame(1, RELAY_MAGIC, RELAY_VERSION, 8'h00, 32'h0, 32'h0);

    // Random: mostly well-formed frames, some bad lengths and broken headers
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      wait_drained();
      apply_settings(seg_max_len[seg], seg_hdr[seg]);
      send_idle_pct = idle_tbl[seg % 4];
      stall_pct     = stall_tbl[seg % 4];
      if (seg == HOLD_SEG) hold_toggle <= ~hold_toggle;
      seg_end = bytes_sent + SEG_BYTES;
      while (bytes_sent < seg_end) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          case ($urandom_range(2))
            0:       send_length(32'd0);
            1:       send_length(cur_max_len + 32'd1);
            default: send_length($urandom() | 32'h8000_0000);
          endcase
        end else begin
          if (!cur_hdr)
            len = $urandom_range(24, 1);
          else if (pick < 18)
            len = $urandom_range(13, 1);
          else if (pick < 25)
            len = 14;
          else
            len = $urandom_range(30, 15);
          if (len > cur_max_len) len = cur_max_len;
          magic   = RELAY_MAGIC;
          version = RELAY_VERSION;
          pick    = $urandom_range(99);
          if (pick < 8) begin
            magic = magic ^ (32'd1 << $urandom_range(31));
          end else if (pick < 15) begin
            version = 8'($urandom_range(255));
            if (version == RELAY_VERSION) version = 8'd0;
          end
          send_relay_frame(len, magic, version, 8'($urandom_range(255)), $urandom(),
                           $urandom());
        end
      end
    end

    wait_drained();
    $display("Checked %0d result beats from %0d stream bytes under %0d register settings,",
             checked_count, bytes_sent, settings_applied);
    $display("with header and raw frames, bad lengths and headers, idle/stall mixes, long hold.");
    if (pending_count != 0)
      $display("%0t: %0d predicted results never arrived", $time, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results still predicted", $time, pending_count);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
